@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each one is clocked on i_clk and
// is held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/alb_pkg.sv @@
`timescale 1ns / 1ps

package alb_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ON_TIME       = 3'd0,
        REG_IDLE_OFF      = 3'd1,
        REG_RECEIVE_OFF   = 3'd2,
        REG_TRANSMIT_OFF  = 3'd3,
        REG_SLEEP_OFF     = 3'd4,
        REG_PULSE_TIME    = 3'd5,
        REG_START_DELAY   = 3'd6
    } t_reg_idx;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 16;

    // Reset values in milliseconds
    localparam int unsigned ON_TIME_RESET      = 80;
    localparam int unsigned IDLE_OFF_RESET     = 500;
    localparam int unsigned RECEIVE_OFF_RESET  = 180;
    localparam int unsigned TRANSMIT_OFF_RESET = 120;
    localparam int unsigned SLEEP_OFF_RESET    = 1200;
    localparam int unsigned PULSE_TIME_RESET   = 120;
    localparam int unsigned START_DELAY_RESET  = 100;

    // Item modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    // One input word
    typedef struct packed {
        logic mode;
        logic sleeping;
        logic transmit_busy;
        logic receive_enabled;
    } t_item;

    // Blink state seen by the top level
    typedef struct packed {
        logic led_lit;
        logic pulse_active;
    } t_status;

endpackage

@@ hw/rtl/activity_led_blinker_core.sv @@
// Activity LED blinker. Each input word is either a one-millisecond tick
// (mode 0) or an event (mode 1) that fires a one-shot pulse; every word
// yields exactly one led_level word giving the LED drive after it. Words
// are taken one per clock while results are being taken: a word is held
// in the input register while the countdown update (one decrement and zero
// compare per counter) runs, and its result is then registered in the
// output register and offered until it is taken. While a result waits
// to be taken, one more word can enter the input register; after that the
// input stalls until the result is taken.
// Registers are written through the cfg port (index 0 on_time .. 6
// start_delay, indexes 7 and up ignored); writing start_delay also reloads
// the wait counter. Configure only while no word is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module activity_led_blinker_core #(
    parameter int DURATION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic                                i_sleeping,
    input  logic                                i_transmit_busy,
    input  logic                                i_receive_enabled,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_led_level,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [alb_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [alb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import alb_pkg::*;

    logic                     r_in_valid;
    t_item                    r_item;
    logic                     r_out_valid;
    logic                     r_led_level;
    logic                     fire;
    logic                     event_fire;
    logic                     led_next;
    t_status                  status;

    logic [DURATION_BITS-1:0] on_time;
    logic [DURATION_BITS-1:0] idle_off;
    logic [DURATION_BITS-1:0] receive_off;
    logic [DURATION_BITS-1:0] transmit_off;
    logic [DURATION_BITS-1:0] sleep_off;
    logic [DURATION_BITS-1:0] pulse_time;
    logic                     delay_load;
    logic [DURATION_BITS-1:0] delay_value;

    // word advances when the result slot is free or being drained
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign event_fire  = fire && (r_item.mode == MODE_EVENT);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{mode: i_mode, sleeping: i_sleeping,
                        transmit_busy: i_transmit_busy,
                        receive_enabled: i_receive_enabled};
        end
    end

    alb_cfg_regs #(
        .DURATION_BITS (DURATION_BITS)
    ) u_cfg_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_on_time      (on_time),
        .o_idle_off     (idle_off),
        .o_receive_off  (receive_off),
        .o_transmit_off (transmit_off),
        .o_sleep_off    (sleep_off),
        .o_pulse_time   (pulse_time),
        .o_delay_load   (delay_load),
        .o_delay_value  (delay_value)
    );

    alb_timer #(
        .DURATION_BITS (DURATION_BITS)
    ) u_timer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (fire),
        .i_item         (r_item),
        .i_on_time      (on_time),
        .i_idle_off     (idle_off),
        .i_receive_off  (receive_off),
        .i_transmit_off (transmit_off),
        .i_sleep_off    (sleep_off),
        .i_pulse_time   (pulse_time),
        .i_delay_load   (delay_load),
        .i_delay_value  (delay_value),
        .o_status       (status),
        .o_led_next     (led_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_led_level <= led_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_level = r_led_level;

    // checks
    `ASSERT_IMPL(a_pulse_lit, status.pulse_active, status.led_lit, "pulse active with LED dark")
    `ASSERT_NEXT(a_event_lit, event_fire, o_out_valid && o_led_level, "event did not light LED")
    `ASSERT_NEXT(a_result_match, fire, o_out_valid && (o_led_level == status.led_lit), "stale LED")

endmodule

@@ hw/rtl/alb_cfg_regs.sv @@
`timescale 1ns / 1ps

module alb_cfg_regs #(
    parameter int DURATION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [alb_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [alb_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic [DURATION_BITS-1:0]             o_on_time,
    output logic [DURATION_BITS-1:0]             o_idle_off,
    output logic [DURATION_BITS-1:0]             o_receive_off,
    output logic [DURATION_BITS-1:0]             o_transmit_off,
    output logic [DURATION_BITS-1:0]             o_sleep_off,
    output logic [DURATION_BITS-1:0]             o_pulse_time,
    output logic                                 o_delay_load,
    output logic [DURATION_BITS-1:0]             o_delay_value
);
    import alb_pkg::*;

    logic [DURATION_BITS-1:0] r_on_time;
    logic [DURATION_BITS-1:0] r_idle_off;
    logic [DURATION_BITS-1:0] r_receive_off;
    logic [DURATION_BITS-1:0] r_transmit_off;
    logic [DURATION_BITS-1:0] r_sleep_off;
    logic [DURATION_BITS-1:0] r_pulse_time;
    logic [DURATION_BITS-1:0] wr_value;

    // write data kept to the duration width
    assign wr_value = DURATION_BITS'(i_cfg_data);

    // register file, out-of-range indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time      <= DURATION_BITS'(ON_TIME_RESET);
            r_idle_off     <= DURATION_BITS'(IDLE_OFF_RESET);
            r_receive_off  <= DURATION_BITS'(RECEIVE_OFF_RESET);
            r_transmit_off <= DURATION_BITS'(TRANSMIT_OFF_RESET);
            r_sleep_off    <= DURATION_BITS'(SLEEP_OFF_RESET);
            r_pulse_time   <= DURATION_BITS'(PULSE_TIME_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ON_TIME:      r_on_time      <= wr_value;
                REG_IDLE_OFF:     r_idle_off     <= wr_value;
                REG_RECEIVE_OFF:  r_receive_off  <= wr_value;
                REG_TRANSMIT_OFF: r_transmit_off <= wr_value;
                REG_SLEEP_OFF:    r_sleep_off    <= wr_value;
                REG_PULSE_TIME:   r_pulse_time   <= wr_value;
                default: ;
            endcase
        end
    end

    // start delay lives only in the wait counter
    assign o_delay_load  = i_cfg_valid && (i_cfg_index == REG_START_DELAY);
    assign o_delay_value = wr_value;

    assign o_on_time      = r_on_time;
    assign o_idle_off     = r_idle_off;
    assign o_receive_off  = r_receive_off;
    assign o_transmit_off = r_transmit_off;
    assign o_sleep_off    = r_sleep_off;
    assign o_pulse_time   = r_pulse_time;

endmodule

@@ hw/rtl/alb_timer.sv @@
`timescale 1ns / 1ps

module alb_timer #(
    parameter int DURATION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  alb_pkg::t_item           i_item,
    input  logic [DURATION_BITS-1:0] i_on_time,
    input  logic [DURATION_BITS-1:0] i_idle_off,
    input  logic [DURATION_BITS-1:0] i_receive_off,
    input  logic [DURATION_BITS-1:0] i_transmit_off,
    input  logic [DURATION_BITS-1:0] i_sleep_off,
    input  logic [DURATION_BITS-1:0] i_pulse_time,
    input  logic                     i_delay_load,
    input  logic [DURATION_BITS-1:0] i_delay_value,
    output alb_pkg::t_status         o_status,
    output logic                     o_led_next
);
    import alb_pkg::*;

    localparam int WAIT_BITS = DURATION_BITS + 1;

    logic                     r_led_lit, n_led_lit;
    logic                     r_pulse_active, n_pulse_active;
    logic [DURATION_BITS-1:0] r_pulse_rem, n_pulse_rem;
    logic [WAIT_BITS-1:0]     r_wait_rem, n_wait_rem;

    logic [DURATION_BITS-1:0] pulse_dec;
    logic [WAIT_BITS-1:0]     wait_dec;
    logic [DURATION_BITS-1:0] off_time;

    // saturating countdowns
    assign pulse_dec = (r_pulse_rem != '0) ? r_pulse_rem - 1'b1 : '0;
    assign wait_dec  = (r_wait_rem != '0) ? r_wait_rem - 1'b1 : '0;

    // off time by flag priority
    always_comb begin
        if (i_item.sleeping) begin
            off_time = i_sleep_off;
        end else if (i_item.transmit_busy) begin
            off_time = i_transmit_off;
        end else if (i_item.receive_enabled) begin
            off_time = i_receive_off;
        end else begin
            off_time = i_idle_off;
        end
    end

    // next blink state for the current word
    always_comb begin
        n_led_lit      = r_led_lit;
        n_pulse_active = r_pulse_active;
        n_pulse_rem    = r_pulse_rem;
        n_wait_rem     = r_wait_rem;
        if (i_item.mode == MODE_EVENT) begin
            n_pulse_rem    = i_pulse_time;
            n_wait_rem     = WAIT_BITS'(i_pulse_time) + WAIT_BITS'(i_on_time);
            n_pulse_active = 1'b1;
            n_led_lit      = 1'b1;
        end else begin
            n_pulse_rem = pulse_dec;
            n_wait_rem  = wait_dec;
            if (r_pulse_active) begin
                if (pulse_dec == '0) begin
                    n_pulse_active = 1'b0;
                    n_led_lit      = 1'b0;
                end
            end else if (wait_dec == '0) begin
                if (r_led_lit) begin
                    n_led_lit  = 1'b0;
                    n_wait_rem = WAIT_BITS'(off_time);
                end else begin
                    n_led_lit  = 1'b1;
                    n_wait_rem = WAIT_BITS'(i_on_time);
                end
            end
        end
    end

    // state registers; a start delay write reloads the wait counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_lit      <= 1'b0;
            r_pulse_active <= 1'b0;
            r_pulse_rem    <= '0;
            r_wait_rem     <= WAIT_BITS'(DURATION_BITS'(START_DELAY_RESET));
        end else begin
            if (i_step) begin
                r_led_lit      <= n_led_lit;
                r_pulse_active <= n_pulse_active;
                r_pulse_rem    <= n_pulse_rem;
                r_wait_rem     <= n_wait_rem;
            end
            if (i_delay_load) begin
                r_wait_rem <= WAIT_BITS'(i_delay_value);
            end
        end
    end

    assign o_led_next            = n_led_lit;
    assign o_status.led_lit      = r_led_lit;
    assign o_status.pulse_active = r_pulse_active;

endmodule

@@ test/tb_activity_led_blinker_core.sv @@
`timescale 1ns / 1ps

module tb_activity_led_blinker_core;
    import alb_pkg::*;

    localparam int REG_COUNT       = 7;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 62;
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 10;
    localparam int CYCLE_LIMIT     = 200000;

    // Index past the register list, must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

    localparam logic PINNED = 1'b1;
    localparam logic FREE   = 1'b0;

    typedef enum logic {ROW_WORD, ROW_WRITE} t_row_kind;

    // One directed step: an input word or a register write
    typedef struct packed {
        t_row_kind                 kind;
        t_item                     w;
        logic                      pinned;
        logic                      pinned_led;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_mode;
    logic                      i_sleeping;
    logic                      i_transmit_busy;
    logic                      i_receive_enabled;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic                      o_led_level;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    // Blinker model state
    logic [15:0] dur_reg [REG_COUNT];
    logic        blink_lit;
    logic        pulse_on;
    logic [15:0] pulse_left;
    logic [16:0] wait_left;

    logic        led_expected [$];
    t_row        stim_rows [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          sender_calm = 0;
    int          receiver_calm = 0;
    int          out_hold = 0;
    logic        led_want;

    activity_led_blinker_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_sleeping        (i_sleeping),
        .i_transmit_busy   (i_transmit_busy),
        .i_receive_enabled (i_receive_enabled),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_led_level       (o_led_level),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Pause before a word; now and then a calm stretch with no pauses at all
    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
        return $urandom_range(0, 6);
    endfunction

    // Mostly short durations so the blink cycles turn over often
    function automatic logic [15:0] draw_duration();
        case ($urandom_range(0, 19))
            0:       return 16'($urandom_range(0, 65535));
            1, 2:    return 16'($urandom_range(0, 40));
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    // LED level after one word; advances the model state
    function automatic logic next_led_level(t_item w);
        logic [15:0] off_ms;
        if (w.sleeping)             off_ms = dur_reg[REG_SLEEP_OFF];
        else if (w.transmit_busy)   off_ms = dur_reg[REG_TRANSMIT_OFF];
        else if (w.receive_enabled) off_ms = dur_reg[REG_RECEIVE_OFF];
        else                        off_ms = dur_reg[REG_IDLE_OFF];

        if (w.mode == MODE_EVENT) begin
            // pulse (re)start, flags ignored
            pulse_left = dur_reg[REG_PULSE_TIME];
            wait_left  = {1'b0, dur_reg[REG_PULSE_TIME]} + {1'b0, dur_reg[REG_ON_TIME]};
            pulse_on   = 1'b1;
            blink_lit  = 1'b1;
        end else begin
            // one millisecond, counters stop at zero
            if (pulse_left != 0) pulse_left--;
            if (wait_left != 0) wait_left--;
            if (pulse_on) begin
                if (pulse_left == 0) begin
                    pulse_on  = 1'b0;
                    blink_lit = 1'b0;
                end
            end else if (wait_left == 0) begin
                if (blink_lit) begin
                    blink_lit = 1'b0;
                    wait_left = {1'b0, off_ms};
                end else begin
                    blink_lit = 1'b1;
                    wait_left = {1'b0, dur_reg[REG_ON_TIME]};
                end
            end
        end
        return blink_lit;
    endfunction

    function automatic t_row word_row(logic mode, logic sl, logic tx, logic rx,
                                      logic pinned, logic led);
        t_row r;
        r = '0;
        r.kind            = ROW_WORD;
        r.w.mode          = mode;
        r.w.sleeping      = sl;
        r.w.transmit_busy = tx;
        r.w.receive_enabled = rx;
        r.pinned          = pinned;
        r.pinned_led      = led;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Offer one word, wait for it to be taken, queue its LED level
    task automatic send_word(input t_item w, input logic pinned, input logic pinned_led);
        int   gap;
        logic led;
        gap = draw_pause(sender_calm);
        // close any register write still held open
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= w.mode;
        i_sleeping        <= w.sleeping;
        i_transmit_busy   <= w.transmit_busy;
        i_receive_enabled <= w.receive_enabled;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        led = next_led_level(w);
        led_expected.push_back(pinned ? pinned_led : led);
    endtask

    // Register write; valid stays up for a following write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (idx < REG_COUNT) begin
            dur_reg[idx] = data;
            // start_delay also reloads the wait counter
            if (idx == REG_START_DELAY) wait_left = {1'b0, data};
        end
    endtask

    // Let every queued word come out, then let the pipeline drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (led_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (led_expected.size() == 0) begin
                    $display("%0t: led_level %0b with nothing expected", $time, o_led_level);
                    mismatches++;
                end else begin
                    led_want = led_expected.pop_front();
                    if (o_led_level !== led_want) begin
                        $display("%0t: led_level expected %0b, got %0b",
                                 $time, led_want, o_led_level);
                        mismatches++;
                    end
                end
                out_hold = draw_pause(receiver_calm);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            i_out_ready <= (out_hold == 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_activity_led_blinker_core failed");
            $finish;
        end
    end

    initial begin
        t_item       w;
        logic [15:0] v;
        logic        prev_write;

        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_mode            <= MODE_TICK;
        i_sleeping        <= 1'b0;
        i_transmit_busy   <= 1'b0;
        i_receive_enabled <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= REG_ON_TIME;
        i_cfg_data        <= '0;

        // model reset values
        dur_reg[REG_ON_TIME]      = 16'(ON_TIME_RESET);
        dur_reg[REG_IDLE_OFF]     = 16'(IDLE_OFF_RESET);
        dur_reg[REG_RECEIVE_OFF]  = 16'(RECEIVE_OFF_RESET);
        dur_reg[REG_TRANSMIT_OFF] = 16'(TRANSMIT_OFF_RESET);
        dur_reg[REG_SLEEP_OFF]    = 16'(SLEEP_OFF_RESET);
        dur_reg[REG_PULSE_TIME]   = 16'(PULSE_TIME_RESET);
        dur_reg[REG_START_DELAY]  = 16'(START_DELAY_RESET);
        blink_lit  = 1'b0;
        pulse_on   = 1'b0;
        pulse_left = '0;
        wait_left  = 17'(START_DELAY_RESET);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed steps
        stim_rows = '{
            // dark after reset, start delay still running
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, PINNED, 1'b0),
            // new start delay takes over the first blink
            cfg_row(REG_START_DELAY, 16'd1),
            cfg_row(REG_SPARE, 16'hFFFF),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, PINNED, 1'b1),
            // event lights the LED whatever the flags
            word_row(MODE_EVENT, 1'b1, 1'b1, 1'b1, PINNED, 1'b1),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, PINNED, 1'b1),
            // zero durations and distinct off times per flag
            cfg_row(REG_ON_TIME, 16'd0),
            cfg_row(REG_IDLE_OFF, 16'd3),
            cfg_row(REG_RECEIVE_OFF, 16'd2),
            cfg_row(REG_TRANSMIT_OFF, 16'd1),
            cfg_row(REG_SLEEP_OFF, 16'd0),
            cfg_row(REG_PULSE_TIME, 16'd0),
            cfg_row(REG_START_DELAY, 16'd0),
            word_row(MODE_EVENT, 1'b0, 1'b0, 1'b0, PINNED, 1'b1),
            // zero-length pulse ends on the next tick
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            // sleeping wins over the other flags
            word_row(MODE_TICK,  1'b1, 1'b1, 1'b1, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b1, 1'b1, FREE, 1'b0),
            // transmit wins over receive
            word_row(MODE_TICK,  1'b0, 1'b1, 1'b1, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b1, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b1, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            // event during a pulse restarts it
            cfg_row(REG_PULSE_TIME, 16'd2),
            cfg_row(REG_ON_TIME, 16'd1),
            word_row(MODE_EVENT, 1'b0, 1'b0, 1'b0, PINNED, 1'b1),
            word_row(MODE_TICK,  1'b1, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_EVENT, 1'b0, 1'b1, 1'b0, PINNED, 1'b1),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0),
            word_row(MODE_TICK,  1'b0, 1'b0, 1'b0, FREE, 1'b0)
        };

        prev_write = 1'b0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                if (!prev_write) settle();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_word(stim_rows[i].w, stim_rows[i].pinned, stim_rows[i].pinned_led);
            end
            prev_write = (stim_rows[i].kind == ROW_WRITE);
        end

        // Random phases; the first two use all-zero and all-ones durations
        for (int p = 0; p < PHASES; p++) begin
            settle();
            for (int r = 0; r < REG_COUNT; r++) begin
                if (p == 0)      v = '0;
                else if (p == 1) v = '1;
                else             v = draw_duration();
                write_reg(CFG_INDEX_BITS'(r), v);
            end
            if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, 16'($urandom));
            repeat (WORDS_PER_PHASE) begin
                w.mode            = ($urandom_range(0, 5) == 0) ? MODE_EVENT : MODE_TICK;
                w.sleeping        = 1'($urandom_range(0, 1));
                w.transmit_busy   = 1'($urandom_range(0, 1));
                w.receive_enabled = 1'($urandom_range(0, 1));
                send_word(w, FREE, 1'b0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && led_expected.size() == 0) begin
            $display("tb_activity_led_blinker_core passed");
        end else begin
            $display("tb_activity_led_blinker_core failed");
        end
        $finish;
    end

endmodule
